// ----- sv/assert_macros.svh -----
// Assertion macros for the port-level checker of the frame checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define SFCC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfcc assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high
`define SFCC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfcc assertion failed");

`endif

// ----- sv/sfcc_pkg.sv -----
// Types and constants shared by the sensor frame checker modules.
package sfcc_pkg;

   // Frame byte positions
   localparam logic [3:0] POS_HUM_HI  = 4'd2;
   localparam logic [3:0] POS_HUM_LO  = 4'd3;
   localparam logic [3:0] POS_TMP_HI  = 4'd4;
   localparam logic [3:0] POS_TMP_LO  = 4'd5;
   localparam logic [3:0] POS_CRC_LO  = 4'd6;
   localparam logic [3:0] POS_CRC_HI  = 4'd7;
   localparam logic [3:0] POS_IDLE    = 4'd8;

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   // Sensor error flag threshold on the humidity high byte
   localparam logic [7:0]  ERR_THRESH = 8'h80;

   // Discomfort index: N = t*(81000 + 99*h) - 14300*h + 46300000, q = round(N / 100000)
   localparam logic [22:0] IDX_COEF_HT    = 23'd99;
   localparam logic [22:0] IDX_COEF_T     = 23'd81000;
   localparam logic [22:0] IDX_COEF_H     = 23'd14300;
   localparam logic [40:0] IDX_OFFSET     = 41'd46300000;
   localparam logic [40:0] IDX_ROUND      = 41'd50000;
   localparam logic [40:0] IDX_SAT_LIMIT  = 41'd3276800000;
   // x / 3125 == (x * ceil(2^39 / 3125)) >> 39 for any x below 2^27
   localparam logic [27:0] IDX_RECIP       = 28'd175921861;
   localparam int          IDX_RECIP_SHIFT = 39;
   localparam int          IDX_Q_BITS     = 15;
   localparam logic signed [15:0] IDX_MAX = 16'sh7FFF;
   localparam logic signed [15:0] IDX_MIN = 16'sh8000;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_SENSOR_ERR = 2'd1,
      STATUS_CRC_ERR    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CRC,
      ST_CALC,
      ST_SEND
   } state_type;

   typedef enum logic [2:0] {
      DI_IDLE,
      DI_MUL_A,
      DI_MUL_P,
      DI_MUL_C,
      DI_MAG,
      DI_CHECK,
      DI_DIV,
      DI_DONE
   } dci_state_type;

   // Control from the frame sequencer to the CRC unit
   typedef struct packed {
      logic load;
      logic restart;
   } crc_ctl_type;

endpackage

// ----- sv/sensor_frame_crc_checker_core.sv -----
// Sensor frame checker top level: byte sequencer, CRC unit, index unit, result register.
//
// Takes an 8-byte sensor response one byte per item; frame_start marks byte 0 and
// abandons any frame in progress. Bytes 0 to 5 are each accepted, then taken through
// four two-bit steps of the shared CRC shift unit; byte 6 is stored. Byte 7 starts the
// discomfort index unit: three passes through its one multiplier, magnitude and
// saturation steps, one reciprocal multiply on the same multiplier for the divide by
// 100000 (skipped when the index saturates), and a done step. The result item is then
// loaded into the output register from the send state once it is free, so req_stall
// stays high after byte 7 through the index run and longer while the result side
// stalls. req_stall is high while the CRC or index unit is busy or a result waits for
// the output register. Bytes outside a frame are dropped without a result.
module sensor_frame_crc_checker_core
   import sfcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_humidity_tenths,
   output logic [15:0]        rsp_temperature_tenths,
   output logic signed [15:0] rsp_discomfort_tenths
);

   state_type   state_ff, state_in;
   logic [3:0]  pos_ff, pos_in;
   logic [15:0] hum_ff, hum_in;
   logic [15:0] tmp_ff, tmp_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   status_type  status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [15:0]        rsp_hum_ff;
   logic [15:0]        rsp_tmp_ff;
   logic signed [15:0] rsp_dci_ff;

   crc_ctl_type crc_ctl;
   logic [15:0] crc_value;
   logic        crc_done;
   logic        dci_start;
   logic        dci_done;
   logic signed [15:0] dci_result;

   logic        req_fire;
   logic        out_free;
   logic        out_load;
   logic [3:0]  pos_eff;
   logic [15:0] rx_crc;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign pos_eff   = req_frame_start ? 4'd0 : pos_ff;
   assign rx_crc    = {req_rx_byte, crc_lo_ff};
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_SEND) && out_free;

   sfcc_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .data  (req_rx_byte),
      .crc   (crc_value),
      .done  (crc_done)
   );

   sfcc_dci u_dci (
      .clock  (clock),
      .reset  (reset),
      .start  (dci_start),
      .hum    (hum_ff),
      .tmp    (tmp_ff),
      .done   (dci_done),
      .result (dci_result)
   );

   // Frame sequencer: place each byte, drive the CRC and index units
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      hum_in      = hum_ff;
      tmp_in      = tmp_ff;
      crc_lo_in   = crc_lo_ff;
      status_in   = status_ff;
      crc_ctl     = '0;
      dci_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (pos_eff)
                  POS_HUM_HI: hum_in[15:8] = req_rx_byte;
                  POS_HUM_LO: hum_in[7:0]  = req_rx_byte;
                  POS_TMP_HI: tmp_in[15:8] = req_rx_byte;
                  POS_TMP_LO: tmp_in[7:0]  = req_rx_byte;
                  POS_CRC_LO: crc_lo_in    = req_rx_byte;
                  default: begin
                  end
               endcase
               if (pos_eff < POS_CRC_LO) begin
                  crc_ctl.load    = 1'b1;
                  crc_ctl.restart = req_frame_start;
                  pos_in          = pos_eff + 4'd1;
                  state_in        = ST_CRC;
               end else if (pos_eff == POS_CRC_LO) begin
                  pos_in = POS_CRC_HI;
               end else if (pos_eff == POS_CRC_HI) begin
                  // Frame complete: sensor error flag wins over a CRC mismatch
                  pos_in = POS_IDLE;
                  if (hum_ff[15:8] >= ERR_THRESH) begin
                     status_in = STATUS_SENSOR_ERR;
                  end else if (rx_crc != crc_value) begin
                     status_in = STATUS_CRC_ERR;
                  end else begin
                     status_in = STATUS_OK;
                  end
                  dci_start = 1'b1;
                  state_in  = ST_CALC;
               end else begin
                  pos_in = POS_IDLE;
               end
            end
         end
         ST_CRC: begin
            if (crc_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_CALC: begin
            if (dci_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= POS_IDLE;
         hum_ff    <= '0;
         tmp_ff    <= '0;
         crc_lo_ff <= '0;
         status_ff <= STATUS_OK;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         hum_ff    <= hum_in;
         tmp_ff    <= tmp_in;
         crc_lo_ff <= crc_lo_in;
         status_ff <= status_in;
      end
   end

   // Output register: load a finished item, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= status_ff;
         rsp_hum_ff    <= hum_ff;
         rsp_tmp_ff    <= tmp_ff;
         rsp_dci_ff    <= dci_result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_humidity_tenths    = rsp_hum_ff;
   assign rsp_temperature_tenths = rsp_tmp_ff;
   assign rsp_discomfort_tenths  = rsp_dci_ff;

endmodule

// ----- sv/sfcc_crc.sv -----
// Two-bit-per-cycle CRC-16/MODBUS accumulator, four steps per byte.
module sfcc_crc
   import sfcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   input  logic [7:0]  data,
   output logic [15:0] crc,
   output logic        done
);

   logic [15:0] crc_ff, crc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [15:0] base;
   logic [15:0] shift_one;
   logic [15:0] shift_two;

   // Shared shift/xor unit: two reflected polynomial steps
   assign shift_one = crc_ff[0]    ? ((crc_ff >> 1) ^ CRC_POLY)    : (crc_ff >> 1);
   assign shift_two = shift_one[0] ? ((shift_one >> 1) ^ CRC_POLY) : (shift_one >> 1);

   assign base = ctl.restart ? CRC_INIT : crc_ff;
   assign done = busy_ff && (cnt_ff == 2'd3);
   assign crc  = crc_ff;

   // Load the byte, then advance two bits a cycle
   always_comb begin
      crc_in  = crc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctl.load) begin
         crc_in  = base ^ {8'h00, data};
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         crc_in = shift_two;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         cnt_ff  <= 2'd0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- sv/sfcc_dci.sv -----
// Discomfort index unit: one shared multiplier, also used for a reciprocal divide by 100000.
module sfcc_dci
   import sfcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        hum,
   input  logic [15:0]        tmp,
   output logic               done,
   output logic signed [15:0] result
);

   dci_state_type state_ff, state_in;
   logic [22:0] a_ff, a_in;
   logic [40:0] acc_ff, acc_in;
   logic [40:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        sat_ff, sat_in;
   logic [IDX_Q_BITS-1:0] q_ff, q_in;

   logic [26:0] mul_a;
   logic [27:0] mul_b;
   logic [54:0] prod;
   logic [40:0] acc_abs;
   logic signed [15:0] q16;

   // Shared multiplier with operand selection
   always_comb begin
      mul_a = {11'd0, hum};
      mul_b = {5'd0, IDX_COEF_HT};
      case (state_ff)
         DI_MUL_P: begin
            mul_a = {11'd0, tmp};
            mul_b = {5'd0, a_ff};
         end
         DI_MUL_C: begin
            mul_b = {5'd0, IDX_COEF_H};
         end
         DI_DIV: begin
            // Divide by 100000 as (mag >> 5) / 3125 through the reciprocal
            mul_a = mag_ff[31:5];
            mul_b = IDX_RECIP;
         end
         default: begin
         end
      endcase
   end

   assign prod    = {28'd0, mul_a} * {27'd0, mul_b};
   assign acc_abs = acc_ff[40] ? (~acc_ff + 41'd1) : acc_ff;
   assign q16     = signed'({1'b0, q_ff});

   assign done   = (state_ff == DI_DONE);
   assign result = sat_ff ? (neg_ff ? IDX_MIN : IDX_MAX) : (neg_ff ? -q16 : q16);

   // Sequence the multiply, magnitude, saturation check and division
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      acc_in   = acc_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      q_in     = q_ff;
      unique case (state_ff)
         DI_IDLE: begin
            if (start) begin
               state_in = DI_MUL_A;
            end
         end
         DI_MUL_A: begin
            a_in     = prod[22:0] + IDX_COEF_T;
            state_in = DI_MUL_P;
         end
         DI_MUL_P: begin
            acc_in   = {2'b00, prod[38:0]} + IDX_OFFSET;
            state_in = DI_MUL_C;
         end
         DI_MUL_C: begin
            acc_in   = acc_ff - {2'b00, prod[38:0]};
            state_in = DI_MAG;
         end
         DI_MAG: begin
            neg_in   = acc_ff[40];
            mag_in   = acc_abs + IDX_ROUND;
            state_in = DI_CHECK;
         end
         DI_CHECK: begin
            sat_in   = (mag_ff >= IDX_SAT_LIMIT);
            state_in = (mag_ff >= IDX_SAT_LIMIT) ? DI_DONE : DI_DIV;
         end
         DI_DIV: begin
            // Take the quotient from the top of the reciprocal product
            q_in     = prod[IDX_RECIP_SHIFT+IDX_Q_BITS-1:IDX_RECIP_SHIFT];
            state_in = DI_DONE;
         end
         DI_DONE: begin
            state_in = DI_IDLE;
         end
         default: begin
            state_in = DI_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DI_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      acc_ff <= acc_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
      q_ff   <= q_in;
   end

endmodule

// ----- sv/sfcc_checker.sv -----
// Port-level checker for the sensor frame checker, bound to the top level.
`include "assert_macros.svh"

module sfcc_checker
   import sfcc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_rx_byte,
   input logic               req_frame_start,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic [15:0]        rsp_humidity_tenths,
   input logic [15:0]        rsp_temperature_tenths,
   input logic signed [15:0] rsp_discomfort_tenths
);

   logic [8:0]  req_item;
   logic [49:0] rsp_item;
   logic        status_known;
   logic        sensor_flag;

   // Gather each channel's payload and the status decode
   assign req_item     = {req_rx_byte, req_frame_start};
   assign rsp_item     = {rsp_status, rsp_humidity_tenths, rsp_temperature_tenths,
                          rsp_discomfort_tenths};
   assign status_known = (rsp_status == STATUS_OK) || (rsp_status == STATUS_SENSOR_ERR) ||
                         (rsp_status == STATUS_CRC_ERR);
   assign sensor_flag  = (rsp_status == STATUS_SENSOR_ERR);

   // Hold a stalled input item
   `SFCC_ASSERT_NXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_item))

   // Hold a stalled result item
   `SFCC_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // Sensor error status tracks the humidity flag bit
   `SFCC_ASSERT_IMP(a_sensor_err, rsp_valid, sensor_flag == rsp_humidity_tenths[15])

   // Unused status code never shows
   `SFCC_ASSERT_IMP(a_status_code, rsp_valid, status_known)

   // No result right out of reset
   `SFCC_ASSERT_IMP(a_reset_quiet, $past(reset), !rsp_valid)

endmodule

bind sensor_frame_crc_checker_core sfcc_checker u_sfcc_checker (.*);
